>>> rtl/tdpc_pkg.sv
`timescale 1ns / 1ps

package tdpc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int IN_W       = 32;
   localparam int CNT_W      = 32;
   localparam int RSP_W      = ((1 + CNT_W + 7) / 8) * 8;
   localparam int STEP_W     = $clog2(VALUE_BITS);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic mark_prime;
      logic div_start;
      logic div_step;
      logic advance;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_end;
      logic is_small;
      logic past_bound;
      logic div_last;
      logic rem_zero;
      logic out_free;
   } status_type;

endpackage

>>> rtl/tdpc_ctrl.sv
`timescale 1ns / 1ps

module tdpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tdpc_pkg::status_type status,
   output tdpc_pkg::cmd_type    cmd
);
   import tdpc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_end || status.is_small) begin
               state_in = ST_FINISH;
            end else if (status.past_bound) begin
               cmd.mark_prime = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.rem_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/tdpc_datapath.sv
`timescale 1ns / 1ps

module tdpc_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tdpc_pkg::IN_W-1:0]   req_value,
   input  tdpc_pkg::cmd_type           cmd,
   output tdpc_pkg::status_type        status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_prime,
   output logic                        rsp_end,
   output logic [tdpc_pkg::CNT_W-1:0]  rsp_count
);
   import tdpc_pkg::*;

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] n_ff;
   logic [VALUE_BITS-1:0] d_ff;
   logic [VALUE_BITS-1:0] dsq_ff;
   logic [VALUE_BITS-1:0] rem_ff;
   logic [VALUE_BITS-1:0] rem_shift;
   logic [VALUE_BITS-1:0] rem_in;
   logic [STEP_W-1:0]     idx_ff;
   logic                  end_ff;
   logic                  small_ff;
   logic                  prime_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  out_prime_ff;
   logic                  out_end_ff;
   logic [CNT_W-1:0]      out_count_ff;

   assign raw       = VALUE_BITS'($signed(req_value));
   assign rem_shift = {rem_ff[VALUE_BITS-2:0], n_ff[idx_ff]};
   assign rem_in    = (rem_shift >= d_ff) ? (rem_shift - d_ff) : rem_shift;

   always_comb begin
      count_in = count_ff;
      if (end_ff) begin
         count_in = '0;
      end else if (prime_ff && (count_ff != CNT_MAX)) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign status.is_end     = end_ff;
   assign status.is_small   = small_ff;
   assign status.past_bound = dsq_ff > n_ff;
   assign status.div_last   = (idx_ff == '0);
   assign status.rem_zero   = (rem_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff     <= raw;
         d_ff     <= VALUE_BITS'(2);
         dsq_ff   <= VALUE_BITS'(4);
         end_ff   <= &raw;
         small_ff <= raw[VALUE_BITS-1] || (raw < VALUE_BITS'(2));
      end else if (cmd.advance) begin
         d_ff   <= d_ff + VALUE_BITS'(1);
         dsq_ff <= dsq_ff + {d_ff[VALUE_BITS-2:0], 1'b0} + VALUE_BITS'(1);
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         idx_ff <= STEP_W'(VALUE_BITS - 1);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         idx_ff <= idx_ff - STEP_W'(1);
      end
      if (cmd.finish) begin
         out_prime_ff <= prime_ff && !end_ff;
         out_end_ff   <= end_ff;
         out_count_ff <= end_ff ? count_ff : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prime_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            prime_ff <= 1'b0;
         end else if (cmd.mark_prime) begin
            prime_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_prime  = out_prime_ff;
   assign rsp_end    = out_end_ff;
   assign rsp_count  = out_count_ff;

endmodule

>>> rtl/trial_division_prime_counter.sv
`timescale 1ns / 1ps

// Counts the primes in a stream of signed integers by trial division. Each
// accepted value yields one result with its prime flag and the running count
// of primes, which saturates at its maximum. The value -1 ends a run: its
// result carries tlast and the final count, and the count then restarts at
// zero. The block works on one value at a time. Every trial divisor takes
// one bound check, a division in a shift-and-subtract unit that retires one
// dividend bit per cycle, and one divisor update. At most floor(sqrt(n)) - 1
// divisors are tried for a value n. Values below 4, negative values and the
// end marker skip the division loop. The next value is taken while a result
// still waits in the output register.

module trial_division_prime_counter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [31:0] value
   input  logic [tdpc_pkg::IN_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] prime_flag, [32:1] count_so_far, upper bits zero
   output logic [tdpc_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast
);
   import tdpc_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic             rsp_prime;
   logic [CNT_W-1:0] rsp_count;

   tdpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdpc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_prime  (rsp_prime),
      .rsp_end    (rsp_tlast),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_prime});

endmodule

>>> rtl/tdpc_checker.sv
`timescale 1ns / 1ps

module tdpc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tdpc_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast
);
   import tdpc_pkg::*;

   logic [CNT_W-1:0] base_ff;
   logic [CNT_W-1:0] rsp_count;

   assign rsp_count = rsp_tdata[CNT_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         base_ff <= rsp_tlast ? '0 : rsp_count;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_end_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[0] && rsp_count == base_ff)
      else $error("end of run result has a prime flag or a wrong count");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && !rsp_tdata[0] |-> rsp_count == base_ff)
      else $error("count moved on a value that is not prime");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && rsp_tdata[0] |->
         rsp_count == base_ff + CNT_W'(1) || (base_ff == CNT_MAX && rsp_count == CNT_MAX))
      else $error("count did not step by one on a prime");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> test/tb_trial_division_prime_counter.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_counter;
   import tdpc_pkg::*;

   localparam logic [IN_W-1:0] END_MARKER = '1;

   typedef struct packed {
      logic             prime;
      logic             last;
      logic [CNT_W-1:0] count;
   } tally_t;

   typedef struct packed {
      logic [IN_W-1:0] value;
      bit              typed;
      tally_t          want;
   } row_t;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [IN_W-1:0]     req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tlast;

   tally_t              expected_tallies[$];
   logic [CNT_W-1:0]    run_prime_count = '0;
   bit                  quiet_phase     = 1'b0;
   int unsigned         error_count     = 0;
   int unsigned         values_sent     = 0;
   int unsigned         primes_checked  = 0;
   int unsigned         runs_checked    = 0;
   int unsigned         ready_hold      = 0;
   int unsigned         ready_pick;
   tally_t              arrived_want;

   // The directed part: each field extreme, the small values that skip the
   // division loop, squares of primes that stop right at the bound, the
   // largest positive value, and back-to-back end markers.
   row_t directed_rows [0:20] = '{
      '{END_MARKER,       1'b1, '{1'b0, 1'b1, 32'd0}},
      '{32'd0,            1'b1, '{1'b0, 1'b0, 32'd0}},
      '{32'd1,            1'b1, '{1'b0, 1'b0, 32'd0}},
      '{32'h8000_0000,    1'b1, '{1'b0, 1'b0, 32'd0}},
      '{-32'sd7,          1'b1, '{1'b0, 1'b0, 32'd0}},
      '{32'd2,            1'b1, '{1'b1, 1'b0, 32'd1}},
      '{32'd3,            1'b1, '{1'b1, 1'b0, 32'd2}},
      '{32'd4,            1'b1, '{1'b0, 1'b0, 32'd2}},
      '{32'd9,            1'b0, '0},
      '{32'd25,           1'b0, '0},
      '{32'd49,           1'b0, '0},
      '{32'd97,           1'b0, '0},
      '{32'd10201,        1'b0, '0},
      '{32'd1018081,      1'b0, '0},
      '{32'd65537,        1'b0, '0},
      '{32'd2147483646,   1'b0, '0},
      '{32'h5555_5555,    1'b0, '0},
      '{32'h2AAA_AAAA,    1'b0, '0},
      '{32'h7FFF_FFFF,    1'b0, '0},
      '{END_MARKER,       1'b0, '0},
      '{END_MARKER,       1'b1, '{1'b0, 1'b1, 32'd0}}
   };

   trial_division_prime_counter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Works out the tally for one value and advances the running count, or clears it on the end marker.
   function automatic tally_t predict_tally(logic [IN_W-1:0] word);
      logic [VALUE_BITS-1:0] raw;
      longint unsigned       n;
      longint unsigned       d;
      logic                  prime;
      tally_t                t;
      raw   = word[VALUE_BITS-1:0];
      t     = '0;
      prime = 1'b0;
      if (raw == '1) begin
         t.last          = 1'b1;
         t.count         = run_prime_count;
         run_prime_count = '0;
         return t;
      end
      if (!raw[VALUE_BITS-1] && raw >= 2) begin
         n     = raw;
         prime = 1'b1;
         d     = 2;
         while (d <= n / d) begin
            if (n % d == 0) begin
               prime = 1'b0;
               break;
            end
            d++;
         end
      end
      if (prime && run_prime_count != CNT_MAX) begin
         run_prime_count++;
      end
      t.prime = prime;
      t.count = run_prime_count;
      return t;
   endfunction

   function automatic int unsigned pick_gap(bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Holds the value on the bus until its transfer, then records what it
   // should produce. A typed expectation replaces the predicted one.
   task automatic deliver_value(logic [IN_W-1:0] value, bit typed, tally_t want);
      tally_t predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predicted = predict_tally(value);
      expected_tallies.push_back(typed ? want : predicted);
      values_sent++;
   endtask

   task automatic hold_off(int unsigned cycles);
      if (cycles != 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_tallies.size() != 0);
   endtask

   initial begin
      int unsigned     random_sent;
      int unsigned     run_length;
      int unsigned     r;
      int unsigned     root;
      logic [IN_W-1:0] v;
      while (reset !== 1'b0) begin
         @(posedge clock);
      end
      foreach (directed_rows[i]) begin
         deliver_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
         hold_off(pick_gap(1'b0));
      end
      drain_results();

      random_sent = 0;
      while (random_sent < 80) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) == 0) begin
            drain_results();
         end
         run_length = $urandom_range(0, 10);
         repeat (run_length) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               v = $urandom_range(0, 1000);
            end else if (r < 50) begin
               v = $urandom_range(1001, 1 << 20);
            end else if (r < 65) begin
               v = {1'b1, 31'($urandom)};
            end else if (r < 80) begin
               v = $urandom & ~32'd1;
            end else if (r < 90) begin
               root = $urandom_range(3, 1500);
               v    = root * root;
            end else begin
               v = $urandom_range(0, 8) - 5;
            end
            deliver_value(v, 1'b0, '0);
            hold_off(pick_gap(quiet_phase));
            random_sent++;
         end
         // Now and then a run is left open so that two runs merge.
         if ($urandom_range(0, 9) != 0) begin
            deliver_value(END_MARKER, 1'b0, '0);
            hold_off(pick_gap(quiet_phase));
            random_sent++;
         end
      end

      quiet_phase = 1'b0;
      drain_results();
      repeat (200) @(posedge clock);
      $display("Summary: %0d values sent; %0d prime results and %0d end-of-run results checked.",
               values_sent, primes_checked, runs_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tallies.size() == 0) begin
               $display("%0t: result transfer with nothing expected, got flag %0b last %0b count %0d",
                        $time, rsp_tdata[0], rsp_tlast, rsp_tdata[CNT_W:1]);
               error_count++;
            end else begin
               arrived_want = expected_tallies.pop_front();
               if (rsp_tdata[0] !== arrived_want.prime) begin
                  $display("%0t: prime_flag mismatch, expected %0b, got %0b",
                           $time, arrived_want.prime, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tlast !== arrived_want.last) begin
                  $display("%0t: end_of_run mismatch, expected %0b, got %0b",
                           $time, arrived_want.last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[CNT_W:1] !== arrived_want.count) begin
                  $display("%0t: count_so_far mismatch, expected %0d, got %0d",
                           $time, arrived_want.count, rsp_tdata[CNT_W:1]);
                  error_count++;
               end
               if (rsp_tdata[RSP_W-1:CNT_W+1] !== '0) begin
                  $display("%0t: padding bits mismatch, expected 0, got %0h",
                           $time, rsp_tdata[RSP_W-1:CNT_W+1]);
                  error_count++;
               end
               primes_checked += arrived_want.prime;
               runs_checked   += arrived_want.last;
            end
         end
         if (ready_hold != 0) begin
            ready_hold--;
            rsp_tready <= 1'b0;
         end else begin
            ready_pick = $urandom_range(0, 99);
            if (quiet_phase || ready_pick < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               ready_hold = (ready_pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

endmodule
